// File: hdl/rdc_pkg.sv
package rdc_pkg;

   localparam int VALUE_FIELD_W = 64;
   localparam int RADIX_W       = 6;
   localparam int DIGIT_W       = 6;
   localparam int CHAR_W        = 7;
   localparam int STEP_BITS     = 8;

   localparam logic [RADIX_W-1:0] RADIX_RESET = 6'd10;
   localparam logic [RADIX_W-1:0] RADIX_MIN   = 6'd2;
   localparam logic [RADIX_W-1:0] RADIX_MAX   = 6'd36;

   localparam logic [CHAR_W-1:0]  CHAR_BASE_DEC   = 7'd48;
   localparam logic [CHAR_W-1:0]  CHAR_BASE_ALPHA = 7'd87;
   localparam logic [DIGIT_W-1:0] DEC_TOP         = 6'd9;

   typedef struct packed {
      logic               done;
      logic [DIGIT_W-1:0] remainder;
   } rdc_div_status_type;

   function automatic logic [CHAR_W-1:0] digit_to_char(input logic [DIGIT_W-1:0] d);
      logic [CHAR_W-1:0] d_ext;
      d_ext = {1'b0, d};
      if (d > DEC_TOP) begin
         return CHAR_BASE_ALPHA + d_ext;
      end
      return CHAR_BASE_DEC + d_ext;
   endfunction

endpackage

// File: hdl/radix_digit_conversion_top.sv
// Converts an unsigned value (low VALUE_WIDTH bits of req_tdata) into ASCII digits in the
// base held by the radix register (reset 10, writes saturated into 2..36). Digits leave
// most significant first, one beat each, '0'-'9' then 'a'-'z'; the final digit carries
// rsp_tlast, and zero gives the single digit '0'. A number needing more than MAX_DIGITS
// digits keeps only its MAX_DIGITS least significant ones. One shared divider finds
// each digit by restoring division, eight quotient bits a cycle; emission then reads
// the digit store one digit at a time, fetching the next only once the previous one
// has moved into the output register. req_tready is high only between items; the
// last result beat may still wait in the output register while the next item is taken.
module radix_digit_conversion_top
   import rdc_pkg::*;
#(
   parameter int VALUE_WIDTH = 64,
   parameter int MAX_DIGITS  = 64
) (
   input  logic                     clock,
   input  logic                     reset,
   // req_tdata: value
   input  logic                     req_tvalid,
   output logic                     req_tready,
   input  logic [VALUE_FIELD_W-1:0] req_tdata,
   // rsp_tdata: digit_char [6:0], zero [7]
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   output logic [7:0]               rsp_tdata,
   output logic                     rsp_tlast,
   input  logic                     csr_wr_en,
   input  logic [RADIX_W-1:0]       csr_wr_data
);

   localparam int DIV_WIDTH = ((VALUE_WIDTH + STEP_BITS - 1) / STEP_BITS) * STEP_BITS;
   localparam int IDX_W     = $clog2(MAX_DIGITS);
   localparam int CNT_W     = $clog2(MAX_DIGITS + 1);

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_DIVIDE = 2'd1;
   localparam logic [1:0] ST_EMIT   = 2'd2;

   logic [1:0]         state_ff, state_in;
   logic [RADIX_W-1:0] radix_ff, radix_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [CNT_W-1:0]   left_ff, left_in;
   logic               fetch_ff, fetch_in;
   logic               fetch_last_ff, fetch_last_in;
   logic               out_valid_ff, out_valid_in;
   logic [CHAR_W-1:0]  out_char_ff, out_char_in;
   logic               out_last_ff, out_last_in;
   logic [DIGIT_W-1:0] rd_data_ff;

   logic [DIGIT_W-1:0] store_mem [MAX_DIGITS];

   logic                 req_accept;
   logic [DIV_WIDTH-1:0] in_value;
   logic                 in_zero;
   logic                 div_load;
   logic [DIV_WIDTH-1:0] div_dividend;
   logic [DIV_WIDTH-1:0] div_quotient;
   rdc_div_status_type   div_status;
   logic                 div_finish;
   logic [CNT_W-1:0]     count_next;
   logic [CNT_W-1:0]     left_dec;
   logic                 wr_en;
   logic [IDX_W-1:0]     wr_idx;
   logic [DIGIT_W-1:0]   wr_data;
   logic                 rd_go;
   logic [IDX_W-1:0]     rd_idx;
   logic                 out_free;
   logic                 out_load;

   // saturate radix writes into the legal range
   always_comb begin
      radix_in = radix_ff;
      if (csr_wr_en) begin
         if (csr_wr_data < RADIX_MIN) begin
            radix_in = RADIX_MIN;
         end else if (csr_wr_data > RADIX_MAX) begin
            radix_in = RADIX_MAX;
         end else begin
            radix_in = csr_wr_data;
         end
      end
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign req_accept = req_tvalid && req_tready;
   assign in_value   = DIV_WIDTH'(req_tdata[VALUE_WIDTH-1:0]);
   assign in_zero    = (in_value == '0);

   assign count_next = count_ff + CNT_W'(1);
   assign div_finish = (div_quotient == '0) || (count_next == CNT_W'(MAX_DIGITS));
   assign div_load   = (req_accept && !in_zero) ||
                       ((state_ff == ST_DIVIDE) && div_status.done && !div_finish);
   assign div_dividend = (state_ff == ST_IDLE) ? in_value : div_quotient;

   rdc_divider #(
      .DIV_WIDTH (DIV_WIDTH)
   ) u_divider (
      .clock    (clock),
      .reset    (reset),
      .load     (div_load),
      .dividend (div_dividend),
      .radix    (radix_ff),
      .quotient (div_quotient),
      .status   (div_status)
   );

   // store digits least significant first; a zero value writes a single '0' digit
   assign wr_en   = (req_accept && in_zero) || ((state_ff == ST_DIVIDE) && div_status.done);
   assign wr_idx  = (state_ff == ST_IDLE) ? '0 : count_ff[IDX_W-1:0];
   assign wr_data = (state_ff == ST_IDLE) ? '0 : div_status.remainder;

   // walk the store downwards; one read in flight, held until the output slot frees
   assign left_dec = left_ff - CNT_W'(1);
   assign rd_idx   = left_dec[IDX_W-1:0];
   assign rd_go    = (state_ff == ST_EMIT) && (left_ff != '0) && !fetch_ff;
   assign out_free = !out_valid_ff || rsp_tready;
   assign out_load = fetch_ff && out_free;

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      left_in       = left_ff;
      fetch_in      = fetch_ff;
      fetch_last_in = fetch_last_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               if (in_zero) begin
                  left_in  = CNT_W'(1);
                  state_in = ST_EMIT;
               end else begin
                  count_in = '0;
                  state_in = ST_DIVIDE;
               end
            end
         end
         ST_DIVIDE: begin
            if (div_status.done) begin
               count_in = count_next;
               if (div_finish) begin
                  left_in  = count_next;
                  state_in = ST_EMIT;
               end
            end
         end
         ST_EMIT: begin
            if (rd_go) begin
               left_in       = left_dec;
               fetch_in      = 1'b1;
               fetch_last_in = (left_dec == '0);
            end
            if (out_load) begin
               fetch_in = 1'b0;
            end
            if ((left_ff == '0) && !fetch_ff) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // output register: hold until taken, refill from the fetched digit
   always_comb begin
      out_valid_in = out_valid_ff;
      out_char_in  = out_char_ff;
      out_last_in  = out_last_ff;
      if (out_load) begin
         out_valid_in = 1'b1;
         out_char_in  = digit_to_char(rd_data_ff);
         out_last_in  = fetch_last_ff;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         radix_ff      <= RADIX_RESET;
         count_ff      <= '0;
         left_ff       <= '0;
         fetch_ff      <= 1'b0;
         fetch_last_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         radix_ff      <= radix_in;
         count_ff      <= count_in;
         left_ff       <= left_in;
         fetch_ff      <= fetch_in;
         fetch_last_ff <= fetch_last_in;
         out_valid_ff  <= out_valid_in;
      end
      out_char_ff <= out_char_in;
      out_last_ff <= out_last_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_mem[wr_idx] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_go) begin
         rd_data_ff <= store_mem[rd_idx];
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {1'b0, out_char_ff};
   assign rsp_tlast  = out_last_ff;

   a_radix_range: assert property (@(posedge clock) disable iff (reset)
      (radix_ff >= RADIX_MIN) && (radix_ff <= RADIX_MAX))
      else $error("radix register left the legal range");

   a_done_in_divide: assert property (@(posedge clock) disable iff (reset)
      div_status.done |-> (state_ff == ST_DIVIDE))
      else $error("divider finished outside the divide phase");

   a_fetch_in_emit: assert property (@(posedge clock) disable iff (reset)
      fetch_ff |-> (state_ff == ST_EMIT))
      else $error("digit fetch pending outside emission");

   a_left_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT) |-> (left_ff <= CNT_W'(MAX_DIGITS)))
      else $error("digit count beyond store depth");

   a_last_ends_item: assert property (@(posedge clock) disable iff (reset)
      out_load && fetch_last_ff |=> (left_ff == '0))
      else $error("last digit sent with digits still in the store");

endmodule

// File: hdl/rdc_divider.sv
module rdc_divider
   import rdc_pkg::*;
#(
   parameter int DIV_WIDTH = 64
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 load,
   input  logic [DIV_WIDTH-1:0] dividend,
   input  logic [RADIX_W-1:0]   radix,
   output logic [DIV_WIDTH-1:0] quotient,
   output rdc_div_status_type   status
);

   localparam int PASSES = DIV_WIDTH / STEP_BITS;
   localparam int PASS_W = $clog2(PASSES) + 1;

   logic [DIV_WIDTH-1:0] dq_ff, dq_in;
   logic [DIGIT_W-1:0]   rem_ff, rem_in;
   logic [RADIX_W-1:0]   radix_ff, radix_in;
   logic [PASS_W-1:0]    pass_ff, pass_in;
   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;

   logic [STEP_BITS-1:0] top_bits;
   logic [STEP_BITS-1:0] q_bits;
   logic [DIGIT_W-1:0]   rem_step;
   logic [DIGIT_W:0]     trial;
   logic [DIV_WIDTH+STEP_BITS-1:0] dq_shift;

   // eight restoring steps per cycle on the narrow partial remainder
   always_comb begin
      top_bits = dq_ff[DIV_WIDTH-1 -: STEP_BITS];
      rem_step = rem_ff;
      q_bits   = '0;
      trial    = '0;
      for (int i = STEP_BITS - 1; i >= 0; i--) begin
         trial = {rem_step, top_bits[i]};
         if (trial >= {1'b0, radix_ff}) begin
            trial     = trial - {1'b0, radix_ff};
            q_bits[i] = 1'b1;
         end
         rem_step = trial[DIGIT_W-1:0];
      end
      dq_shift = {dq_ff, q_bits};
   end

   always_comb begin
      dq_in    = dq_ff;
      rem_in   = rem_ff;
      radix_in = radix_ff;
      pass_in  = pass_ff;
      busy_in  = busy_ff;
      done_in  = 1'b0;
      if (load) begin
         dq_in    = dividend;
         rem_in   = '0;
         radix_in = radix;
         pass_in  = PASS_W'(PASSES);
         busy_in  = 1'b1;
      end else if (busy_ff) begin
         dq_in   = dq_shift[DIV_WIDTH-1:0];
         rem_in  = rem_step;
         pass_in = pass_ff - PASS_W'(1);
         if (pass_ff == PASS_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         pass_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         pass_ff <= pass_in;
      end
      dq_ff    <= dq_in;
      rem_ff   <= rem_in;
      radix_ff <= radix_in;
   end

   assign quotient         = dq_ff;
   assign status.done      = done_ff;
   assign status.remainder = rem_ff;

endmodule

// File: sim/testbench.sv
`timescale 1ns / 100ps

module testbench;
   import rdc_pkg::*;

   // Block sizes under test; the predictor follows the same values.
   localparam int TB_VALUE_W = 64;
   localparam int TB_DIGITS  = 64;
   localparam logic [VALUE_FIELD_W-1:0] VALUE_MASK =
      (TB_VALUE_W >= VALUE_FIELD_W) ? '1 : ((64'd1 << TB_VALUE_W) - 64'd1);

   // Longest stretch with no beat moving on either side: it must cover the division of
   // a 64-digit number before its first digit leaves, plus gaps and stalls.
   localparam int QUIET_LIMIT = 4000;
   // Cycles to hold after the last digit so the block settles into idle.
   localparam int SETTLE_CYCLES = 8;
   localparam int RANDOM_PHASES = 8;
   localparam int PHASE_ITEMS   = 50;

   typedef struct packed {
      logic [CHAR_W-1:0] digit_char;
      logic              last_digit;
   } digit_beat_type;

   logic                     clock;
   logic                     reset;
   logic                     req_tvalid;
   logic                     req_tready;
   logic [VALUE_FIELD_W-1:0] req_tdata;
   logic                     rsp_tvalid;
   logic                     rsp_tready;
   logic [7:0]               rsp_tdata;
   logic                     rsp_tlast;
   logic                     csr_wr_en;
   logic [RADIX_W-1:0]       csr_wr_data;

   // Radix the block should hold, and the digits still owed by it, oldest first.
   logic [RADIX_W-1:0] current_radix;
   digit_beat_type     pending_digits [$];
   int                 error_count;
   int                 quiet_cycles;
   // Random idling on each side; cleared for stretches at full rate.
   bit                 sender_idles;
   bit                 receiver_idles;

   radix_digit_conversion_top #(
      .VALUE_WIDTH (TB_VALUE_W),
      .MAX_DIGITS  (TB_DIGITS)
   ) u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Saturate a raw register write into the legal base range.
   function automatic logic [RADIX_W-1:0] clamp_radix(input logic [RADIX_W-1:0] raw);
      if (raw < RADIX_MIN) begin
         return RADIX_MIN;
      end
      if (raw > RADIX_MAX) begin
         return RADIX_MAX;
      end
      return raw;
   endfunction

   // Divide repeatedly by the current radix, then queue the digits most
   // significant first. Digits beyond the store depth are dropped from the top.
   function automatic void queue_digits(input logic [VALUE_FIELD_W-1:0] raw);
      logic [VALUE_FIELD_W-1:0] rest;
      logic [DIGIT_W-1:0]       found [TB_DIGITS];
      int                       count;
      digit_beat_type           beat;
      rest  = raw & VALUE_MASK;
      count = 0;
      if (rest == '0) begin
         found[0] = '0;
         count    = 1;
      end else begin
         while (rest != '0 && count < TB_DIGITS) begin
            found[count] = DIGIT_W'(rest % current_radix);
            rest         = rest / current_radix;
            count++;
         end
      end
      for (int k = count - 1; k >= 0; k--) begin
         beat.digit_char = {1'b0, found[k]} +
                           ((found[k] > DEC_TOP) ? CHAR_BASE_ALPHA : CHAR_BASE_DEC);
         beat.last_digit = (k == 0);
         pending_digits.push_back(beat);
      end
   endfunction

   // Offer one value after a random gap; leave tvalid high after the beat so a
   // back-to-back item keeps it raised.
   task automatic send_value(input logic [VALUE_FIELD_W-1:0] value);
      int unsigned gap;
      gap = sender_idles ? $urandom_range(0, 14) : 0;
      @(negedge clock);
      if (gap != 0) begin
         req_tvalid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tdata  = value;
      do @(posedge clock); while (!req_tready);
      queue_digits(value);
   endtask

   // Drop tvalid and hold until every owed digit has arrived, then let the block settle.
   task automatic drain_block();
      @(negedge clock);
      req_tvalid = 1'b0;
      while (pending_digits.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // Write the radix register, after first draining the block.
   task automatic write_radix(input logic [RADIX_W-1:0] raw);
      drain_block();
      csr_wr_en   = 1'b1;
      csr_wr_data = raw;
      @(negedge clock);
      csr_wr_en     = 1'b0;
      current_radix = clamp_radix(raw);
   endtask

   function automatic logic [VALUE_FIELD_W-1:0] random_value();
      logic [VALUE_FIELD_W-1:0] raw;
      int unsigned              pick;
      raw  = {$urandom, $urandom};
      pick = $urandom_range(0, 9);
      if (pick == 0) begin
         return '0;
      end
      if (pick == 1) begin
         return raw | 64'hFF00_0000_0000_0000;
      end
      // Most values get a random width so digit counts spread widely.
      return raw >> $urandom_range(0, 63);
   endfunction

   // Base 10 straight out of reset, with small values, a two-digit value and the top.
   task automatic test_reset_radix();
      send_value(64'd0);
      send_value(64'd1);
      send_value(64'd9);
      send_value(64'd10);
      send_value(64'd12345);
      send_value('1);
   endtask

   // Both ends of the base range, writes that saturate, and letters at both ends.
   task automatic test_radix_extremes();
      write_radix(6'd0);
      send_value('1);
      send_value(64'd0);
      send_value(64'd1);
      send_value(64'h8000_0000_0000_0000);
      write_radix(6'd1);
      send_value(64'd5);
      write_radix(6'd36);
      send_value('1);
      send_value(64'd35);
      send_value(64'd36);
      send_value(64'd10);
      write_radix(6'd63);
      send_value(64'd0);
      write_radix(6'd37);
      send_value(64'd1295);
      write_radix(6'd16);
      send_value(64'hDEAD_BEEF_0123_4567);
      send_value(64'd15);
      write_radix(6'd2);
      send_value(64'd6);
   endtask

   // Hold the sender until the block has emptied, then resume mid-setting.
   task automatic test_sender_pause();
      write_radix(6'd10);
      repeat (3) send_value(random_value());
      drain_block();
      repeat (3) send_value(random_value());
   endtask

   // Random values over a series of radix settings; idling off for some phases.
   task automatic test_random_values();
      logic [RADIX_W-1:0] raw;
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         raw = ($urandom_range(0, 3) == 0) ? RADIX_W'($urandom_range(0, 63))
                                           : RADIX_W'($urandom_range(2, 36));
         write_radix(raw);
         sender_idles   = (phase % 3 != 2) && (phase != 4);
         receiver_idles = (phase % 3 != 2);
         repeat (PHASE_ITEMS) send_value(random_value());
      end
      sender_idles   = 1'b1;
      receiver_idles = 1'b1;
   endtask

   // Sink side: stall a random number of cycles before each digit.
   initial begin
      int unsigned stall;
      rsp_tready = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         stall = receiver_idles ? $urandom_range(0, 14) : 0;
         if (stall != 0) begin
            rsp_tready = 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_tready = 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         @(negedge clock);
      end
   end

   // Compare every digit beat with the oldest owed one.
   always @(posedge clock) begin
      digit_beat_type owed;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_digits.size() == 0) begin
            $error("digit beat with nothing owed: digit_char %0d last_digit %0b",
                   rsp_tdata[CHAR_W-1:0], rsp_tlast);
            error_count++;
         end else begin
            owed = pending_digits.pop_front();
            if (rsp_tdata[CHAR_W-1:0] !== owed.digit_char) begin
               $error("digit_char: expected %0d, got %0d",
                      owed.digit_char, rsp_tdata[CHAR_W-1:0]);
               error_count++;
            end
            if (rsp_tlast !== owed.last_digit) begin
               $error("last_digit: expected %0b, got %0b", owed.last_digit, rsp_tlast);
               error_count++;
            end
            if (rsp_tdata[7] !== 1'b0) begin
               $error("tdata pad bit: expected 0, got %0b", rsp_tdata[7]);
               error_count++;
            end
         end
      end
   end

   // Watchdog: end the run if no beat moves on either side for too long.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("FAIL radix_digit_conversion_top");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      reset          = 1'b1;
      req_tvalid     = 1'b0;
      req_tdata      = '0;
      csr_wr_en      = 1'b0;
      csr_wr_data    = '0;
      current_radix  = RADIX_RESET;
      error_count    = 0;
      quiet_cycles   = 0;
      sender_idles   = 1'b1;
      receiver_idles = 1'b1;
      repeat (11) @(negedge clock);
      reset = 1'b0;

      test_reset_radix();
      test_radix_extremes();
      test_sender_pause();
      test_random_values();

      drain_block();
      repeat (20) @(posedge clock);
      if (pending_digits.size() != 0) begin
         $error("digits still owed at end: %0d", pending_digits.size());
         error_count++;
      end
      if (error_count == 0) begin
         $display("PASS radix_digit_conversion_top");
      end else begin
         $display("FAIL radix_digit_conversion_top");
      end
      $finish;
   end

endmodule

// File: files.f
hdl/rdc_pkg.sv
hdl/rdc_divider.sv
hdl/radix_digit_conversion_top.sv
sim/testbench.sv
